// ===== rtl/tsss_pkg.sv =====
`default_nettype none

package tsss_pkg;

	localparam int unsigned NUM_VALUES = 24;
	localparam int unsigned FRAME_TICKS = 10;

	localparam logic [7:0] CMD_VOLTAGE = 8'h0a;
	localparam logic [7:0] CMD_CURRENT = 8'h05;
	localparam logic [7:0] CMD_CURRENT_SECOND = 8'h55;
	localparam logic [7:0] ENABLE_BYTE_RESET = 8'h10;
	localparam logic [23:0] DIRECT_FLAGS_RESET = 24'h000000;
	localparam logic [7:0] LAST_TICK_RESET = 8'd31;

	// Ticks at which the second and third frames start, and the tick that closes the scan.
	localparam logic [7:0] FRAME1_TICK = 8'd10;
	localparam logic [7:0] FRAME2_TICK = 8'd20;
	localparam logic [7:0] SCAN_END_TICK = 8'd30;
	localparam logic [3:0] STATUS_POS = 4'd9;

	typedef enum logic [0:0] {
		OP_TICK  = 1'b0,
		OP_WRITE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		CAP_CURRENT = 2'd0,
		CAP_VOLTAGE = 2'd1,
		CAP_STATUS  = 2'd2
	} cap_kind_t;

	typedef enum logic [2:0] {
		REG_ENABLE_FIRST  = 3'd0,
		REG_ENABLE_SECOND = 3'd1,
		REG_ENABLE_THIRD  = 3'd2,
		REG_DIRECT_FLAGS  = 3'd3,
		REG_LAST_TICK     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [2:0][7:0] enable_byte;
		logic [23:0]     direct_flags;
		logic [7:0]      last_tick;
	} cfg_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [7:0]  rx_byte;
		logic [4:0]  value_index;
		logic [7:0]  value_data;
	} in_item_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic [2:0]  select_n;
		logic        cap_valid;
		cap_kind_t   cap_kind;
		logic [4:0]  cap_index;
		logic [7:0]  cap_value;
	} out_item_t;

	// Fixed interleaving of the 24 measurement slots over the three frames.
	function automatic logic [4:0] phase_slot(input logic [4:0] idx);
		logic [4:0] slot;
		unique case (idx)
			5'd0:  slot = 5'd0;
			5'd1:  slot = 5'd1;
			5'd2:  slot = 5'd6;
			5'd3:  slot = 5'd7;
			5'd4:  slot = 5'd12;
			5'd5:  slot = 5'd13;
			5'd6:  slot = 5'd18;
			5'd7:  slot = 5'd19;
			5'd8:  slot = 5'd2;
			5'd9:  slot = 5'd3;
			5'd10: slot = 5'd8;
			5'd11: slot = 5'd9;
			5'd12: slot = 5'd14;
			5'd13: slot = 5'd15;
			5'd14: slot = 5'd20;
			5'd15: slot = 5'd21;
			5'd16: slot = 5'd4;
			5'd17: slot = 5'd5;
			5'd18: slot = 5'd10;
			5'd19: slot = 5'd11;
			5'd20: slot = 5'd16;
			5'd21: slot = 5'd17;
			5'd22: slot = 5'd22;
			5'd23: slot = 5'd23;
			default: slot = 5'd0;
		endcase
		return slot;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/tsss_if.sv =====
`default_nettype none

interface tsss_in_if;
	logic       valid;
	logic       ready;
	logic [0:0] opcode;
	logic [7:0] rx_byte;
	logic [4:0] value_index;
	logic [7:0] value_data;

	modport source (output valid, output opcode, output rx_byte, output value_index,
		output value_data, input ready);
	modport sink (input valid, input opcode, input rx_byte, input value_index,
		input value_data, output ready);
endinterface

interface tsss_out_if;
	logic       valid;
	logic       ready;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic [2:0] select_n;
	logic       cap_valid;
	logic [1:0] cap_kind;
	logic [4:0] cap_index;
	logic [7:0] cap_value;

	modport source (output valid, output tx_valid, output tx_byte, output select_n,
		output cap_valid, output cap_kind, output cap_index, output cap_value,
		input ready);
	modport sink (input valid, input tx_valid, input tx_byte, input select_n,
		input cap_valid, input cap_kind, input cap_index, input cap_value,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/tsss_cfg.sv =====
`default_nettype none

module tsss_cfg
	import tsss_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output cfg_t             cfg
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_byte <= {3{ENABLE_BYTE_RESET}};
			cfg_q.direct_flags <= DIRECT_FLAGS_RESET;
			cfg_q.last_tick <= LAST_TICK_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ENABLE_FIRST:  cfg_q.enable_byte[0] <= pwdata[7:0];
				REG_ENABLE_SECOND: cfg_q.enable_byte[1] <= pwdata[7:0];
				REG_ENABLE_THIRD:  cfg_q.enable_byte[2] <= pwdata[7:0];
				REG_DIRECT_FLAGS:  cfg_q.direct_flags <= pwdata[23:0];
				REG_LAST_TICK:     cfg_q.last_tick <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ENABLE_FIRST:  prdata = {24'd0, cfg_q.enable_byte[0]};
			REG_ENABLE_SECOND: prdata = {24'd0, cfg_q.enable_byte[1]};
			REG_ENABLE_THIRD:  prdata = {24'd0, cfg_q.enable_byte[2]};
			REG_DIRECT_FLAGS:  prdata = {8'd0, cfg_q.direct_flags};
			REG_LAST_TICK:     prdata = {24'd0, cfg_q.last_tick};
			default:           prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/tsss_seq.sv =====
`default_nettype none

module tsss_seq
	import tsss_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cfg_t     cfg,
	input  wire logic     advance,
	input  wire in_item_t item,
	output out_item_t     res
);

	logic [7:0] tick_q;
	logic       volt_q;
	logic [2:0] sel_q;
	logic [7:0] values_q [NUM_VALUES];

	logic [7:0] tick_next;
	logic [7:0] tick_inc;
	logic       volt_next;
	logic [2:0] sel_next;
	logic [1:0] frame;
	logic [3:0] pos;
	logic [4:0] slot;
	logic [7:0] cmd_base;
	logic [7:0] enable_sel;
	logic       is_tick;

	assign is_tick = (item.opcode == OP_TICK);
	assign tick_inc = tick_q + 8'd1;
	assign slot = phase_slot({frame, 3'b000} + 5'(pos) - 5'd1);

	always_comb begin
		priority if (tick_q >= FRAME2_TICK) begin
			frame = 2'd2;
			pos = 4'(tick_q - FRAME2_TICK);
		end else if (tick_q >= FRAME1_TICK) begin
			frame = 2'd1;
			pos = 4'(tick_q - FRAME1_TICK);
		end else begin
			frame = 2'd0;
			pos = tick_q[3:0];
		end
	end

	always_comb begin
		unique case (frame)
			2'd0:    enable_sel = cfg.enable_byte[0];
			2'd1:    enable_sel = cfg.enable_byte[1];
			2'd2:    enable_sel = cfg.enable_byte[2];
			default: enable_sel = cfg.enable_byte[0];
		endcase
		if (volt_q) begin
			cmd_base = CMD_VOLTAGE;
		end else if (frame == 2'd1) begin
			cmd_base = CMD_CURRENT_SECOND;
		end else begin
			cmd_base = CMD_CURRENT;
		end
	end

	always_comb begin
		res = '0;
		sel_next = sel_q;
		volt_next = volt_q;
		tick_next = tick_q;
		if (is_tick) begin
			tick_next = (tick_inc > cfg.last_tick) ? 8'd0 : tick_inc;
			if (tick_q < SCAN_END_TICK) begin
				res.tx_valid = 1'b1;
				if (pos == 4'd0) begin
					// A frame opens by selecting its slave alone.
					sel_next = ~(3'b001 << frame);
					res.tx_byte = cmd_base | enable_sel;
				end else if (pos < STATUS_POS) begin
					res.cap_valid = 1'b1;
					res.cap_kind = volt_q ? CAP_VOLTAGE : CAP_CURRENT;
					res.cap_index = slot;
					res.cap_value = item.rx_byte;
					res.tx_byte = values_q[slot];
				end else begin
					res.cap_valid = 1'b1;
					res.cap_kind = CAP_STATUS;
					res.cap_index = {3'b000, frame};
					res.cap_value = item.rx_byte;
					res.tx_byte = cfg.direct_flags[8*frame +: 8];
				end
			end else if (tick_q == SCAN_END_TICK) begin
				sel_next = 3'b111;
				volt_next = ~volt_q;
			end
		end
		res.select_n = sel_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= 8'd0;
			volt_q <= 1'b0;
			sel_q <= 3'b111;
		end else if (advance) begin
			tick_q <= tick_next;
			volt_q <= volt_next;
			sel_q <= sel_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VALUES; i++) begin
				values_q[i] <= 8'd0;
			end
		end else if (advance && !is_tick && (item.value_index < 5'(NUM_VALUES))) begin
			values_q[item.value_index] <= item.value_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/three_slave_spi_scan_sequencer_top.sv =====
`default_nettype none

// Three-slave SPI scan sequencer. Every scan tick brings the byte received by the
// previous SPI transfer and returns one result: the next byte to shift out, the
// chip selects, and the received byte tagged as a current, voltage or status
// capture. Write transactions update the 24 output value bytes and return a
// result with nothing to send or capture. One transaction is accepted every
// clock cycle while results are taken; each result passes the input register and
// then the result register before it reaches the output, and the sequencer state
// moves as an item leaves the input register. While a result waits on the output,
// one more transaction is held in the input register and the input then stalls.
// The user must write configuration over the APB port only while no transaction
// is in flight (not enforced by the block); it has no clearing pass after reset.
module three_slave_spi_scan_sequencer_top
	import tsss_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	tsss_in_if.sink          item,
	tsss_out_if.source       result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_d;
	out_item_t res_q;
	logic      res_valid_q;
	logic      advance;

	assign pready = 1'b1;
	assign advance = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	tsss_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	tsss_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (advance),
		.item    (item_s1),
		.res     (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.opcode <= opcode_t'(item.opcode);
			item_s1.rx_byte <= item.rx_byte;
			item_s1.value_index <= item.value_index;
			item_s1.value_data <= item.value_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign result.valid = res_valid_q;
	assign result.tx_valid = res_q.tx_valid;
	assign result.tx_byte = res_q.tx_byte;
	assign result.select_n = res_q.select_n;
	assign result.cap_valid = res_q.cap_valid;
	assign result.cap_kind = res_q.cap_kind;
	assign result.cap_index = res_q.cap_index;
	assign result.cap_value = res_q.cap_value;

`ifndef SYNTHESIS
	// A status byte is only captured inside a frame, with exactly one slave selected.
	a_status_one_select: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.cap_valid && (result.cap_kind == CAP_STATUS))
		|-> ($countones(result.select_n) == 2))
		else $error("status capture without a single selected slave");

	// A write transaction yields a result with nothing sent and nothing captured.
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (item_s1.opcode == OP_WRITE))
		|=> (res_valid_q && !res_q.tx_valid && !res_q.cap_valid))
		else $error("write transaction produced a send or a capture");

	// Input back-pressure only comes from a stalled result register.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (res_valid_q && !result.ready))
		else $error("input stalled while the result side could move");
`endif

endmodule

`default_nettype wire
